/* rtl/drg_pkg.sv */
// Package of shared constants, types and helper functions for the ripple grid.
`timescale 1ns / 1ps

package drg_pkg;

    // Grid geometry
    localparam int GRID_W = 128;
    localparam int GRID_H = 128;
    localparam int CELLS  = GRID_W * GRID_H;
    localparam int XW     = $clog2(GRID_W);
    localparam int YW     = $clog2(GRID_H);
    localparam int AW     = $clog2(CELLS);
    localparam int CW     = ((XW > YW) ? XW : YW) + 1;
    localparam int DW     = 2 * CW;
    localparam int SH_LEN = 2 * GRID_W + 1;

    // Iterative unit step counts
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 14;
    localparam int STEP_W     = 5;

    // Configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_DAMPING = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_POWER   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_RADIUS  = 2'd2;

    // Request codes
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_IMPULSE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] cell_x;
        logic [6:0] cell_y;
    } req_t;

    typedef struct packed {
        logic [7:0]         gray_level;
        logic signed [15:0] raw_height;
        logic               done_res;
    } res_t;

    typedef enum logic [1:0] {
        OUT_DONE,
        OUT_READ,
        OUT_REJECT
    } out_kind_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      cnt_inc;
        logic      clr_wr;
        logic      latch_req;
        logic      t1_issue;
        logic      t2_issue;
        logic      imp_chk;
        logic      sq_init;
        logic      sq_step;
        logic      mul1;
        logic      mul2;
        logic      dv_init;
        logic      dv_step;
        logic      imp_wr;
        logic      rd_issue;
        logic      out_load;
        out_kind_t out_kind;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic cnt_last;
        logic pipe_busy;
        logic in_bowl;
        logic sq_last;
        logic dv_last;
    } dp_stat_t;

    // Saturate a wide signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
        logic signed [15:0] r;
        begin
            if (v > 40'sd32767)
                r = 16'sh7FFF;
            else if (v < -40'sd32768)
                r = 16'sh8000;
            else
                r = v[15:0];
            return r;
        end
    endfunction

endpackage

/* rtl/drg_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module drg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/drg_datapath.sv */
// Datapath of the ripple grid: height memories, scan counter, tick pipeline and impulse unit.
`timescale 1ns / 1ps

module drg_datapath
    import drg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  req_t              req,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    output res_t              res,
    output logic              res_strobe
);

    // Configuration registers
    logic [15:0] damping_reg;
    logic [15:0] power_reg;
    logic [7:0]  radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= 16'd65470;
            power_reg   <= 16'd6554;
            radius_reg  <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DAMPING: damping_reg <= cfg_data;
                CFG_POWER:   power_reg   <= cfg_data;
                CFG_RADIUS:  radius_reg  <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    logic signed [16:0] dmp_s;
    logic [15:0]        r2;
    assign dmp_s = $signed({1'b0, damping_reg});
    assign r2    = 16'(radius_reg * radius_reg);

    // Cell scan counter, kept as a linear address and as column and row.
    logic [AW-1:0] cnt_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic          cnt_last;

    assign cnt_last = (cnt_reg == AW'(CELLS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            x_reg   <= '0;
            y_reg   <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            if (cnt_last)
            begin
                cnt_reg <= '0;
                x_reg   <= '0;
                y_reg   <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + AW'(1);
                if (x_reg == XW'(GRID_W - 1))
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + YW'(1);
                end
                else
                begin
                    x_reg <= x_reg + XW'(1);
                end
            end
        end
    end

    // Request capture, with the cell clamped into the grid.
    logic [XW-1:0] cx_reg;
    logic [YW-1:0] cy_reg;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            cx_reg <= (32'(req.cell_x) > 32'(GRID_W - 1)) ? XW'(GRID_W - 1) : XW'(req.cell_x);
            cy_reg <= (32'(req.cell_y) > 32'(GRID_H - 1)) ? YW'(GRID_H - 1) : YW'(req.cell_y);
        end
    end

    assign rd_addr = AW'(32'(cy_reg) * GRID_W + 32'(cx_reg));

    // Memory ports
    logic          cur_we,  prev_we,  nxt_we;
    logic [AW-1:0] cur_wa,  prev_wa,  nxt_wa;
    logic [15:0]   cur_wd,  prev_wd,  nxt_wd;
    logic [AW-1:0] cur_ra,  prev_ra;
    logic [15:0]   cur_rd,  prev_rd,  nxt_rd;
    logic signed [15:0] cur_q, prev_q, nxt_q;

    assign cur_q  = $signed(cur_rd);
    assign prev_q = $signed(prev_rd);
    assign nxt_q  = $signed(nxt_rd);

    drg_ram #(.WIDTH(16), .DEPTH(CELLS)) u_cur (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_wa),
        .wdata (cur_wd),
        .raddr (cur_ra),
        .rdata (cur_rd)
    );

    drg_ram #(.WIDTH(16), .DEPTH(CELLS)) u_prev (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_wa),
        .wdata (prev_wd),
        .raddr (prev_ra),
        .rdata (prev_rd)
    );

    drg_ram #(.WIDTH(16), .DEPTH(CELLS)) u_nxt (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_wa),
        .wdata (nxt_wd),
        .raddr (cnt_reg),
        .rdata (nxt_rd)
    );

    // Tick pipeline: stage 0 is the memory read, stages 1 and 2 are registers.
    logic          v0_reg, v1_reg, v2_reg;
    logic          m0_reg, m1_reg, m2_reg;
    logic          int0_reg;
    logic [AW-1:0] a0_reg, a1_reg, a2_reg;
    logic [AW-1:0] centre_addr;
    logic          centre_int;

    // The centre lags the read address by one row and one cell.
    assign centre_addr = cnt_reg - AW'(GRID_W + 1);
    assign centre_int  = (32'(x_reg) >= 2) && (32'(y_reg) >= 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= cmd.t1_issue | cmd.t2_issue;
            v1_reg <= v0_reg & int0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m0_reg   <= cmd.t2_issue;
        int0_reg <= cmd.t2_issue | centre_int;
        a0_reg   <= cmd.t2_issue ? cnt_reg : centre_addr;
        m1_reg   <= m0_reg;
        a1_reg   <= a0_reg;
        m2_reg   <= m1_reg;
        a2_reg   <= a1_reg;
    end

    // Row line of current heights for the four neighbours.
    logic signed [15:0] sh_reg [SH_LEN];

    always_ff @(posedge clk)
    begin
        if (v0_reg && !m0_reg)
        begin
            sh_reg[0] <= cur_q;
            for (int j = 1; j < SH_LEN; j++)
            begin
                sh_reg[j] <= sh_reg[j-1];
            end
        end
    end

    // Stage 1: neighbour sum minus twice previous, or the blend differences.
    logic signed [17:0] sum4;
    logic signed [18:0] tv;
    logic signed [18:0] tv_reg;
    logic signed [16:0] dp_reg, dc_reg;
    logic signed [15:0] p1_reg, c1_reg, p2_reg, c2_reg;

    assign sum4 = 18'(sh_reg[0]) + 18'(sh_reg[GRID_W-1])
                + 18'(sh_reg[GRID_W+1]) + 18'(sh_reg[2*GRID_W]);
    assign tv   = 19'(sum4) - (19'(prev_q) <<< 1);

    always_ff @(posedge clk)
    begin
        tv_reg <= tv;
        dp_reg <= 17'(cur_q) - 17'(prev_q);
        dc_reg <= 17'(nxt_q) - 17'(cur_q);
        p1_reg <= prev_q;
        c1_reg <= cur_q;
    end

    // Stage 2: multiply by the damping factor.
    logic signed [35:0] t1_prod;
    logic signed [33:0] mp, mc;
    logic signed [35:0] t1_prod_reg;
    logic signed [33:0] mp_reg, mc_reg;

    assign t1_prod = tv_reg * dmp_s;
    assign mp      = dp_reg * dmp_s;
    assign mc      = dc_reg * dmp_s;

    always_ff @(posedge clk)
    begin
        t1_prod_reg <= t1_prod;
        mp_reg      <= mp;
        mc_reg      <= mc;
        p2_reg      <= p1_reg;
        c2_reg      <= c1_reg;
    end

    // Stage 3: round to nearest, saturate and write back.
    logic signed [35:0] t1_rnd;
    logic signed [33:0] mp_rnd, mc_rnd;
    logic signed [15:0] nxt_new, prev_new, cur_blend;

    assign t1_rnd    = (t1_prod_reg + 36'sd65536) >>> 17;
    assign mp_rnd    = (mp_reg + 34'sd32768) >>> 16;
    assign mc_rnd    = (mc_reg + 34'sd32768) >>> 16;
    assign nxt_new   = sat16(40'(t1_rnd));
    assign prev_new  = sat16(40'(p2_reg) + 40'(mp_rnd));
    assign cur_blend = sat16(40'(c2_reg) + 40'(mc_rnd));

    // Impulse: distance check for the cell under the counter.
    logic signed [CW-1:0] dx, dy;
    logic signed [DW-1:0] dx2, dy2, dd;
    logic                 interior;

    assign dx  = CW'($signed({1'b0, x_reg})) - CW'($signed({1'b0, cx_reg}));
    assign dy  = CW'($signed({1'b0, y_reg})) - CW'($signed({1'b0, cy_reg}));
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign dd  = dx2 + dy2;
    assign interior = (32'(x_reg) >= 1) && (32'(x_reg) <= GRID_W - 2)
                   && (32'(y_reg) >= 1) && (32'(y_reg) <= GRID_H - 2);

    logic               in_bowl_reg;
    logic [15:0]        dist_reg;
    logic signed [15:0] cur_hold;
    logic [31:0]        sq_v, sq_res, sq_bit;
    logic [31:0]        sq_sum;
    logic [15:0]        rim;
    logic [31:0]        rim_sq_reg;
    logic [47:0]        pw_prod_reg;
    logic [48:0]        msum;
    logic [15:0]        dv_rem;
    logic [13:0]        dv_q;
    logic [16:0]        rem_sh;
    logic               rem_ge;
    logic [STEP_W-1:0]  step_reg;
    logic signed [15:0] imp_new;

    assign sq_sum = sq_res + sq_bit;
    assign rim    = {radius_reg, 8'd0} - sq_res[15:0];
    assign msum   = 49'(pw_prod_reg) + (49'(r2) << 18);
    assign rem_sh = {dv_rem, dv_q[13]};
    assign rem_ge = rem_sh >= {1'b0, r2};
    assign imp_new = sat16(40'(cur_hold) - 40'(dv_q));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bowl_reg <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            if (cmd.imp_chk)
            begin
                in_bowl_reg <= interior && (32'(dd) < 32'(r2));
            end
            if (cmd.sq_init || cmd.dv_init)
            begin
                step_reg <= '0;
            end
            else if (cmd.sq_step || cmd.dv_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // Square root one bit pair a step, then the bowl depth and its division by R squared.
    always_ff @(posedge clk)
    begin
        if (cmd.imp_chk)
        begin
            dist_reg <= 16'(dd);
        end
        if (cmd.sq_init)
        begin
            cur_hold <= cur_q;
            sq_v     <= {dist_reg, 16'd0};
            sq_res   <= '0;
            sq_bit   <= 32'h4000_0000;
        end
        else if (cmd.sq_step)
        begin
            if (sq_v >= sq_sum)
            begin
                sq_v   <= sq_v - sq_sum;
                sq_res <= (sq_res >> 1) + sq_bit;
            end
            else
            begin
                sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
        end
        if (cmd.mul1)
        begin
            rim_sq_reg <= rim * rim;
        end
        if (cmd.mul2)
        begin
            pw_prod_reg <= 48'(power_reg) * 48'(rim_sq_reg);
        end
        if (cmd.dv_init)
        begin
            dv_rem <= msum[48:33];
            dv_q   <= msum[32:19];
        end
        else if (cmd.dv_step)
        begin
            dv_rem <= rem_ge ? 16'(rem_sh - {1'b0, r2}) : rem_sh[15:0];
            dv_q   <= {dv_q[12:0], rem_ge};
        end
    end

    // Memory port selection
    always_comb
    begin
        cur_ra  = cmd.rd_issue ? rd_addr : cnt_reg;
        prev_ra = cmd.t1_issue ? centre_addr : cnt_reg;

        cur_we  = 1'b0;
        cur_wa  = cnt_reg;
        cur_wd  = '0;
        prev_we = 1'b0;
        prev_wa = cnt_reg;
        prev_wd = '0;
        nxt_we  = 1'b0;
        nxt_wa  = cnt_reg;
        nxt_wd  = '0;

        if (cmd.clr_wr)
        begin
            cur_we  = 1'b1;
            prev_we = 1'b1;
            nxt_we  = 1'b1;
        end
        else if (cmd.imp_wr)
        begin
            cur_we = 1'b1;
            cur_wd = imp_new;
        end
        else if (v2_reg && m2_reg)
        begin
            cur_we  = 1'b1;
            cur_wa  = a2_reg;
            cur_wd  = cur_blend;
            prev_we = 1'b1;
            prev_wa = a2_reg;
            prev_wd = prev_new;
        end
        else if (v2_reg)
        begin
            nxt_we = 1'b1;
            nxt_wa = a2_reg;
            nxt_wd = nxt_new;
        end
    end

    // Display level of a read cell.
    logic signed [25:0] gnum;
    logic [7:0]         gray;

    assign gnum = 26'sd2088960 - (26'(cur_q) <<< 9) + (26'(cur_q) <<< 1);

    always_comb
    begin
        if (gnum < 26'sd0)
            gray = 8'd0;
        else if (gnum[25:14] > 12'd255)
            gray = 8'd255;
        else
            gray = gnum[21:14];
    end

    // Result register, shown for one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_strobe <= 1'b0;
        end
        else
        begin
            res_strobe <= cmd.out_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_kind)
                OUT_READ:
                begin
                    res.gray_level <= gray;
                    res.raw_height <= cur_q;
                    res.done_res   <= 1'b1;
                end
                OUT_DONE:
                begin
                    res.gray_level <= '0;
                    res.raw_height <= '0;
                    res.done_res   <= 1'b1;
                end
                default:
                begin
                    res.gray_level <= '0;
                    res.raw_height <= '0;
                    res.done_res   <= 1'b0;
                end
            endcase
        end
    end

    assign stat.cnt_last  = cnt_last;
    assign stat.pipe_busy = v0_reg | v1_reg | v2_reg;
    assign stat.in_bowl   = in_bowl_reg;
    assign stat.sq_last   = (step_reg == STEP_W'(SQRT_STEPS - 1));
    assign stat.dv_last   = (step_reg == STEP_W'(DIV_STEPS - 1));

endmodule

/* rtl/drg_ctrl.sv */
// Controller state machine of the ripple grid: sequences clearing, tick, impulse and read.
`timescale 1ns / 1ps

module drg_ctrl
    import drg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] req_type,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd,
    output logic       busy
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_T1,
        S_T1_DRAIN,
        S_T2,
        S_T2_DRAIN,
        S_I_CHK,
        S_I_DEC,
        S_I_SQRT,
        S_I_MUL1,
        S_I_MUL2,
        S_I_PREP,
        S_I_DIV,
        S_I_WR,
        S_RD_ISSUE,
        S_RD_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch_req = 1'b1;
                    unique case (req_type)
                        REQ_TICK:    state_next = S_T1;
                        REQ_IMPULSE: state_next = S_I_CHK;
                        REQ_READ:    state_next = S_RD_ISSUE;
                        default:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = OUT_REJECT;
                        end
                    endcase
                end
            end
            S_T1:
            begin
                cmd.t1_issue = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_last)
                    state_next = S_T1_DRAIN;
            end
            S_T1_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = S_T2;
            end
            S_T2:
            begin
                cmd.t2_issue = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_last)
                    state_next = S_T2_DRAIN;
            end
            S_T2_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_DONE;
                    state_next   = S_IDLE;
                end
            end
            S_I_CHK:
            begin
                cmd.imp_chk = 1'b1;
                state_next  = S_I_DEC;
            end
            S_I_DEC:
            begin
                if (stat.in_bowl)
                begin
                    cmd.sq_init = 1'b1;
                    state_next  = S_I_SQRT;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    if (stat.cnt_last)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = OUT_DONE;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_I_CHK;
                    end
                end
            end
            S_I_SQRT:
            begin
                cmd.sq_step = 1'b1;
                if (stat.sq_last)
                    state_next = S_I_MUL1;
            end
            S_I_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_I_MUL2;
            end
            S_I_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_I_PREP;
            end
            S_I_PREP:
            begin
                cmd.dv_init = 1'b1;
                state_next  = S_I_DIV;
            end
            S_I_DIV:
            begin
                cmd.dv_step = 1'b1;
                if (stat.dv_last)
                    state_next = S_I_WR;
            end
            S_I_WR:
            begin
                cmd.imp_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_last)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_DONE;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_I_CHK;
                end
            end
            S_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                cmd.out_load = 1'b1;
                cmd.out_kind = OUT_READ;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

/* rtl/damped_ripple_grid.sv */
// Top level of the damped ripple grid: controller and datapath.
`timescale 1ns / 1ps

// Damped water-ripple grid of GRID_W by GRID_H heights in signed Q2.13.
// Requests: a word on req is taken at a clock edge where start is high and
// busy is low. A tick advances the simulation, an impulse presses a bowl
// into the current grid round a cell, a read returns one cell's height.
// Each request gives one result word on res, valid for exactly one cycle
// while res_strobe is high; the receiver cannot hold it off.
// A tick takes two scans of the grid through the memory ports. An impulse
// checks each cell in turn and runs the iterative square root and divider
// for each interior cell inside the radius. An unknown request is answered
// with done_res showing zero. One request is worked at a time; busy stays
// high until its result word is loaded. Configuration writes on
// cfg_we/cfg_index/cfg_data take effect at once and must only be made
// while busy is low.
// Reset: the three height memories are swept to zero, one address a cycle,
// over all CELLS addresses with busy high; registers return to defaults.

module damped_ripple_grid
    import drg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              req,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data,
    output res_t              res,
    output logic              res_strobe
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    drg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    drg_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .res        (res),
        .res_strobe (res_strobe)
    );

endmodule

/* rtl/drg_checker.sv */
// Port-level checks of the ripple grid and their binding to the top level.
`timescale 1ns / 1ps

module drg_checker
    import drg_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input res_t res,
    input logic res_strobe
);

    // A valid request makes the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.req_type == REQ_TICK || req.req_type == REQ_IMPULSE
            || req.req_type == REQ_READ) |=> busy)
    else $error("valid request did not raise busy");

    // A result word is never shown while a request is still at work.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe |-> !busy)
    else $error("result word shown while busy");

    // A word without completion is all zero and follows an unknown request.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && !res.done_res |->
            res.gray_level == 8'd0 && res.raw_height == 16'sd0
            && $past(start && !busy && req.req_type != REQ_TICK
                && req.req_type != REQ_IMPULSE && req.req_type != REQ_READ))
    else $error("incomplete result word is wrong");

    // A negative height always reads as the lighter half of the grey scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_strobe && res.raw_height[15] |-> res.gray_level >= 8'd127)
    else $error("grey level does not match height sign");

endmodule

bind damped_ripple_grid drg_checker u_drg_checker (.*);

/* dv/tb_damped_ripple_grid.sv */
// Self-checking testbench for the damped ripple grid, with its own model of the height grids.
`timescale 1ns / 1ps

module tb_damped_ripple_grid;
    import drg_pkg::*;

    localparam int  WATCHDOG_LIMIT = 3000000;
    localparam int  MAX_REPORTS    = 10;
    localparam int  DRAIN_CYCLES   = 20;
    localparam byte MID_GRAY       = 8'd127;

    // One row of the directed part: a request word and, optionally, its known result.
    typedef struct packed {
        req_t rq;
        logic known;
        res_t want;
    } dir_row_t;

    localparam res_t DONE_WORD  = '{8'd0, 16'sd0, 1'b1};
    localparam res_t FLAT_READ  = '{MID_GRAY, 16'sd0, 1'b1};
    localparam res_t ZERO_WORD  = '{8'd0, 16'sd0, 1'b0};
    localparam res_t NO_VALUE   = '{8'd0, 16'sd0, 1'b0};
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    localparam int DIR_ROWS = 18;
    localparam dir_row_t DIR_STIM [DIR_ROWS] = '{
        '{'{REQ_READ,    7'd0,   7'd0},   1'b1, FLAT_READ},
        '{'{REQ_READ,    7'd127, 7'd127}, 1'b1, FLAT_READ},
        '{'{REQ_READ,    7'd127, 7'd0},   1'b1, FLAT_READ},
        '{'{REQ_READ,    7'd0,   7'd127}, 1'b1, FLAT_READ},
        '{'{REQ_UNKNOWN, 7'd5,   7'd9},   1'b1, ZERO_WORD},
        '{'{REQ_TICK,    7'd0,   7'd0},   1'b1, DONE_WORD},
        '{'{REQ_IMPULSE, 7'd64,  7'd64},  1'b1, DONE_WORD},
        '{'{REQ_READ,    7'd64,  7'd64},  1'b0, NO_VALUE},
        '{'{REQ_READ,    7'd65,  7'd64},  1'b0, NO_VALUE},
        '{'{REQ_IMPULSE, 7'd0,   7'd0},   1'b1, DONE_WORD},
        '{'{REQ_IMPULSE, 7'd127, 7'd127}, 1'b1, DONE_WORD},
        '{'{REQ_READ,    7'd1,   7'd1},   1'b0, NO_VALUE},
        '{'{REQ_TICK,    7'd127, 7'd127}, 1'b1, DONE_WORD},
        '{'{REQ_READ,    7'd64,  7'd64},  1'b0, NO_VALUE},
        '{'{REQ_READ,    7'd63,  7'd65},  1'b0, NO_VALUE},
        '{'{REQ_UNKNOWN, 7'd127, 7'd127}, 1'b1, ZERO_WORD},
        '{'{REQ_IMPULSE, 7'd1,   7'd126}, 1'b1, DONE_WORD},
        '{'{REQ_READ,    7'd1,   7'd126}, 1'b0, NO_VALUE}
    };

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    req_t              req;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    res_t              res;
    logic              res_strobe;

    // Model state: the three grids and the register copies.
    shortint     cur_h [CELLS];
    shortint     prv_h [CELLS];
    shortint     nxt_h [CELLS];
    longint      damp_q16;
    longint      power_q16;
    longint      radius_cells;

    res_t        pending_words [$];
    int          mismatches;
    int          idle_cycles;
    bit          burst_mode;
    int          burst_left;
    logic [6:0]  last_cx;
    logic [6:0]  last_cy;

    damped_ripple_grid u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res),
        .res_strobe(res_strobe)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic shortint clip16(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return shortint'(v);
    endfunction

    // Divide by 2^s, rounding to nearest with ties upward.
    function automatic longint round_div_pow2(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint floor_sqrt(input longint v);
        longint r;
        longint t;
        r = 0;
        for (int k = 15; k >= 0; k--)
        begin
            t = r | (longint'(1) << k);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // One simulation step of the whole grid.
    task automatic advance_ripple();
        longint sum4;
        longint p;
        longint c;
        longint n;
        int     i;
        for (int y = 1; y < GRID_H - 1; y++)
        begin
            for (int x = 1; x < GRID_W - 1; x++)
            begin
                i = x + y * GRID_W;
                sum4 = longint'(cur_h[i-1]) + cur_h[i+1] + cur_h[i-GRID_W] + cur_h[i+GRID_W];
                nxt_h[i] = clip16(round_div_pow2((sum4 - 2 * longint'(prv_h[i])) * damp_q16, 17));
            end
        end
        for (int j = 0; j < CELLS; j++)
        begin
            p = prv_h[j];
            c = cur_h[j];
            n = nxt_h[j];
            prv_h[j] = clip16(p + round_div_pow2((c - p) * damp_q16, 16));
            cur_h[j] = clip16(c + round_div_pow2((n - c) * damp_q16, 16));
        end
    endtask

    // Press a quadratic bowl into the current grid.
    task automatic press_bowl(input int cx, input int cy);
        longint r2;
        longint den;
        longint dd;
        longint a;
        longint delta;
        int     i;
        r2 = radius_cells * radius_cells;
        if (radius_cells == 0)
            return;
        den = r2 << 19;
        for (int y = 1; y < GRID_H - 1; y++)
        begin
            for (int x = 1; x < GRID_W - 1; x++)
            begin
                dd = longint'((x - cx) * (x - cx) + (y - cy) * (y - cy));
                if (dd < r2)
                begin
                    a = radius_cells * 256 - floor_sqrt(dd << 16);
                    delta = (power_q16 * a * a + (den >> 1)) / den;
                    i = x + y * GRID_W;
                    cur_h[i] = clip16(longint'(cur_h[i]) - delta);
                end
            end
        end
    endtask

    // Update the model for one request and return the word it should produce.
    task automatic predict_word(input req_t rq, output res_t word);
        longint h;
        longint num;
        word = ZERO_WORD;
        case (rq.req_type)
            REQ_TICK:
            begin
                advance_ripple();
                word.done_res = 1'b1;
            end
            REQ_IMPULSE:
            begin
                press_bowl(int'(rq.cell_x), int'(rq.cell_y));
                word.done_res = 1'b1;
            end
            REQ_READ:
            begin
                h = cur_h[int'(rq.cell_x) + int'(rq.cell_y) * GRID_W];
                num = 2088960 - 510 * h;
                if (num < 0)
                    word.gray_level = 8'd0;
                else if ((num >> 14) > 255)
                    word.gray_level = 8'd255;
                else
                    word.gray_level = 8'(num >> 14);
                word.raw_height = 16'(h);
                word.done_res = 1'b1;
            end
            default:
            begin
                word = ZERO_WORD;
            end
        endcase
    endtask

    // Hand one request to the block after a random gap, or none in a burst; the model runs at acceptance.
    task automatic issue_request(input req_t rq, input bit known, input res_t want);
        int   gap;
        res_t word;
        if (burst_left == 0)
        begin
            burst_mode = ~burst_mode;
            burst_left = $urandom_range(4, 12);
        end
        burst_left--;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= rq;
        do
            @(posedge clk);
        while (busy);
        predict_word(rq, word);
        pending_words.push_back(known ? want : word);
        if (rq.req_type == REQ_IMPULSE)
        begin
            last_cx = rq.cell_x;
            last_cy = rq.cell_y;
        end
    endtask

    // Let everything drain, then write all three registers while the block is idle.
    task automatic load_registers(input logic [15:0] damp, input logic [15:0] power,
                                  input logic [7:0] radius);
        @(negedge clk);
        start <= 1'b0;
        wait (pending_words.size() == 0);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DAMPING;
        cfg_data  <= damp;
        @(negedge clk);
        cfg_index <= CFG_POWER;
        cfg_data  <= power;
        @(negedge clk);
        cfg_index <= CFG_RADIUS;
        cfg_data  <= {8'd0, radius};
        @(negedge clk);
        cfg_we    <= 1'b0;
        damp_q16     = damp;
        power_q16    = power;
        radius_cells = radius;
    endtask

    // Random request: mostly reads, some near the last bowl, with ticks, impulses and some unknown codes.
    function automatic req_t random_request();
        req_t rq;
        int   k;
        k = $urandom_range(0, 99);
        rq.cell_x = 7'($urandom_range(0, 127));
        rq.cell_y = 7'($urandom_range(0, 127));
        if (k < 62)
        begin
            rq.req_type = REQ_READ;
            if (k < 30)
            begin
                rq.cell_x = last_cx + 7'($urandom_range(0, 6)) - 7'd3;
                rq.cell_y = last_cy + 7'($urandom_range(0, 6)) - 7'd3;
            end
        end
        else if (k < 78)
            rq.req_type = REQ_TICK;
        else if (k < 93)
            rq.req_type = REQ_IMPULSE;
        else
            rq.req_type = REQ_UNKNOWN;
        return rq;
    endfunction

    // Result checking against the oldest expected word.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_strobe)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result word %h", $realtime, res);
            end
            else
            begin
                want = pending_words.pop_front();
                if (res.gray_level !== want.gray_level || res.raw_height !== want.raw_height
                    || res.done_res !== want.done_res)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: result mismatch: expected gray %0d height %0d done %0b,",
                                  " got gray %0d height %0d done %0b"},
                                 $realtime, want.gray_level, want.raw_height, want.done_res,
                                 res.gray_level, res.raw_height, res.done_res);
                end
            end
        end
    end

    // Watchdog on cycles where no word moves in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || res_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stimulus sequence.
    initial
    begin
        req_t rq;
        start      = 1'b0;
        req        = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_DAMPING;
        cfg_data   = '0;
        rst_n      = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        burst_mode = 1'b0;
        burst_left = 0;
        last_cx    = 7'd64;
        last_cy    = 7'd64;
        damp_q16     = 65470;
        power_q16    = 6554;
        radius_cells = 3;
        for (int i = 0; i < CELLS; i++)
        begin
            cur_h[i] = 0;
            prv_h[i] = 0;
            nxt_h[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset register values.
        for (int i = 0; i < DIR_ROWS; i++)
            issue_request(DIR_STIM[i].rq, DIR_STIM[i].known, DIR_STIM[i].want);

        // No damping, no power, a radius of one cell.
        load_registers(16'd0, 16'd0, 8'd1);
        for (int i = 0; i < 10; i++)
            issue_request(random_request(), 1'b0, NO_VALUE);

        // Full damping, full power and the largest radius: one bowl over the whole grid.
        load_registers(16'hFFFF, 16'hFFFF, 8'd255);
        issue_request('{REQ_IMPULSE, 7'd64, 7'd64}, 1'b0, NO_VALUE);
        issue_request('{REQ_READ, 7'd64, 7'd64}, 1'b0, NO_VALUE);
        issue_request('{REQ_READ, 7'd1, 7'd1}, 1'b0, NO_VALUE);
        issue_request('{REQ_TICK, 7'd0, 7'd0}, 1'b0, NO_VALUE);
        issue_request('{REQ_READ, 7'd2, 7'd100}, 1'b0, NO_VALUE);

        // Nominal settings, drawn at random.
        for (int phase = 0; phase < 2; phase++)
        begin
            load_registers(16'($urandom_range(58982, 65535)), 16'($urandom),
                           8'($urandom_range(1, 12)));
            for (int i = 0; i < 35; i++)
            begin
                rq = random_request();
                issue_request(rq, 1'b0, NO_VALUE);
            end
        end

        // Drain and finish.
        @(negedge clk);
        start <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
rtl/drg_pkg.sv
rtl/drg_ram.sv
rtl/drg_datapath.sv
rtl/drg_ctrl.sv
rtl/damped_ripple_grid.sv
rtl/drg_checker.sv
dv/tb_damped_ripple_grid.sv
